/* rtl/ksa_pkg.sv */
// Shared types and codes for the shared-array stack block.
package ksa_pkg;

   localparam int DATA_W = 32;
   localparam int ID_W   = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                     operation;
      logic [ID_W-1:0]          stack_id;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] pop_value;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_OVER  = 2'd2,
      KIND_UNDER = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [ID_W-1:0]          stack_id;
      logic signed [DATA_W-1:0] push_value;
   } cmd_type;

endpackage

/* rtl/k_stacks_shared_array.sv */
// Top level of the shared-array stack block.
// NUM_STACKS LIFO stacks share CAPACITY slots of one store; each request word
// is a push or a pop on one stack and yields exactly one response word (status
// and popped value). In the back end, the idle state reads the slot store at
// the stack head or free-list head; the apply state, held while the response
// is stalled, applies the update and loads the response. A two-word queue sits
// between request intake and the back end. Slots are handed out from the list
// of freed slots while it holds any, otherwise from a fresh counter until it
// reaches CAPACITY, so no clearing pass is needed after reset.
module k_stacks_shared_array #(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ksa_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ksa_pkg::rsp_type  rsp_word
);

   logic             q_full;
   logic             q_push;
   logic             q_valid;
   logic             q_pop;
   ksa_pkg::cmd_type front_cmd;
   ksa_pkg::cmd_type back_cmd;

   ksa_front #(
      .NUM_STACKS (NUM_STACKS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (front_cmd)
   );

   ksa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (back_cmd)
   );

   ksa_back #(
      .NUM_STACKS (NUM_STACKS),
      .CAPACITY   (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (back_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

/* rtl/ksa_front.sv */
// Front end: accepts request words and classifies them into commands.
module ksa_front #(
   parameter int NUM_STACKS = 4
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  ksa_pkg::req_type  req_word,
   input  logic              q_full,
   output logic              q_push,
   output ksa_pkg::cmd_type  q_cmd
);

   logic in_range;

   assign in_range  = int'(req_word.stack_id) < NUM_STACKS;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.stack_id   = req_word.stack_id;
      q_cmd.push_value = req_word.push_value;
      if (req_word.operation == ksa_pkg::OP_POP) begin
         q_cmd.kind = in_range ? ksa_pkg::KIND_POP : ksa_pkg::KIND_UNDER;
      end else begin
         q_cmd.kind = in_range ? ksa_pkg::KIND_PUSH : ksa_pkg::KIND_OVER;
      end
   end

endmodule

/* rtl/ksa_queue.sv */
// Two-entry command queue between front and back.
module ksa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ksa_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ksa_pkg::cmd_type  pop_cmd
);

   ksa_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/ksa_back.sv */
// Back end: stack heads, free list, slot store and the response register.
module ksa_back #(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ksa_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ksa_pkg::rsp_type  rsp_word
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   ksa_pkg::cmd_type               cmd_ff;
   ksa_pkg::cmd_type               cmd_in;
   logic [LW-1:0]                  head_ff;
   logic [LW-1:0]                  head_in;
   logic [LW-1:0]                  heads_ff [NUM_STACKS];
   logic [LW-1:0]                  heads_in [NUM_STACKS];
   logic [LW-1:0]                  free_head_ff;
   logic [LW-1:0]                  free_head_in;
   logic [LW-1:0]                  fresh_ff;
   logic [LW-1:0]                  fresh_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   ksa_pkg::rsp_type               rsp_ff;
   ksa_pkg::rsp_type               rsp_in;

   logic [ksa_pkg::DATA_W-1:0]     value_mem [CAPACITY];
   logic [LW-1:0]                  link_mem [CAPACITY];
   logic [ksa_pkg::DATA_W-1:0]     value_rd_ff;
   logic [LW-1:0]                  link_rd_ff;

   logic                           rd_en;
   logic [LW-1:0]                  rd_addr;
   logic                           value_we;
   logic                           link_we;
   logic [LW-1:0]                  wr_slot;
   logic [LW-1:0]                  link_wd;
   logic [SW-1:0]                  q_idx;
   logic [SW-1:0]                  cmd_idx;
   logic                           out_free;

   assign q_idx     = SW'(q_cmd.stack_id);
   assign cmd_idx   = SW'(cmd_ff.stack_id);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign rd_addr   = (q_cmd.kind == ksa_pkg::KIND_POP) ? heads_ff[q_idx] : free_head_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      heads_in     = heads_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      value_we     = 1'b0;
      link_we      = 1'b0;
      wr_slot      = head_ff;
      link_wd      = free_head_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_cmd;
               head_in  = heads_ff[q_idx];
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = ksa_pkg::ST_OK;
               rsp_in.pop_value = '0;
               state_in         = S_IDLE;
               unique case (cmd_ff.kind)
                  ksa_pkg::KIND_PUSH: begin
                     if (free_head_ff != NULL_LINK) begin
                        wr_slot      = free_head_ff;
                        free_head_in = link_rd_ff;
                        value_we     = 1'b1;
                     end else if (fresh_ff != NULL_LINK) begin
                        wr_slot  = fresh_ff;
                        fresh_in = fresh_ff + LW'(1);
                        value_we = 1'b1;
                     end else begin
                        rsp_in.status = ksa_pkg::ST_OVERFLOW;
                     end
                     if (value_we) begin
                        link_we           = 1'b1;
                        link_wd           = head_ff;
                        heads_in[cmd_idx] = wr_slot;
                     end
                  end
                  ksa_pkg::KIND_POP: begin
                     if (head_ff != NULL_LINK) begin
                        rsp_in.pop_value  = value_rd_ff;
                        heads_in[cmd_idx] = link_rd_ff;
                        link_we           = 1'b1;
                        wr_slot           = head_ff;
                        link_wd           = free_head_ff;
                        free_head_in      = head_ff;
                     end else begin
                        rsp_in.status = ksa_pkg::ST_UNDERFLOW;
                     end
                  end
                  ksa_pkg::KIND_OVER: begin
                     rsp_in.status = ksa_pkg::ST_OVERFLOW;
                  end
                  default: begin
                     rsp_in.status = ksa_pkg::ST_UNDERFLOW;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[wr_slot[IW-1:0]] <= cmd_ff.push_value;
      end
      if (link_we) begin
         link_mem[wr_slot[IW-1:0]] <= link_wd;
      end
      if (rd_en) begin
         value_rd_ff <= value_mem[rd_addr[IW-1:0]];
         link_rd_ff  <= link_mem[rd_addr[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      head_ff <= head_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= NULL_LINK;
         fresh_ff     <= '0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            heads_ff[i] <= NULL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         heads_ff     <= heads_in;
      end
   end

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NULL_LINK)
      else $error("fresh slot counter past capacity");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("response raised outside apply step");

   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && out_free && cmd_ff.kind == ksa_pkg::KIND_POP
       && head_ff != NULL_LINK) |=> free_head_ff == $past(head_ff))
      else $error("popped slot not returned to free list");

   a_queue_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_APPLY && !q_pop)
      else $error("command taken while busy");

endmodule

/* tb/sv/tb_k_stacks_shared_array.sv */
// Self-checking testbench for the shared-array stack block: directed and random push/pop traffic.
module tb_k_stacks_shared_array;

   localparam int STACKS     = 4;
   localparam int CAP        = 16;
   localparam int LINK_W     = $clog2(CAP) + 1;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_WAIT  = 20;

   typedef enum logic [1:0] {
      STALL_NONE   = 2'd0,
      STALL_LIGHT  = 2'd1,
      STALL_HEAVY  = 2'd2,
      STALL_TOGGLE = 2'd3
   } stall_kind_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ksa_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ksa_pkg::rsp_type rsp_word;

   logic signed [ksa_pkg::DATA_W-1:0] slot_data [CAP];
   logic [LINK_W-1:0]                 slot_next [CAP];
   logic [LINK_W-1:0]                 stack_top [STACKS];
   logic [LINK_W-1:0]                 free_top;

   ksa_pkg::rsp_type awaited_rsp [$];
   int               error_count = 0;
   int               idle_cycles = 0;
   int               burst_left  = 0;
   bit               drive_high  = 1'b0;
   bit               req_take;
   bit               rsp_take;
   ksa_pkg::rsp_type rsp_seen;
   stall_kind_type   stall_mode  = STALL_NONE;
   int               stall_left  = 0;

   k_stacks_shared_array #(
      .NUM_STACKS(STACKS),
      .CAPACITY  (CAP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always #10 clock = ~clock;

   function automatic void reset_stacks();
      for (int i = 0; i < CAP; i++) begin
         slot_next[i] = LINK_W'(i + 1);
      end
      for (int i = 0; i < STACKS; i++) begin
         stack_top[i] = LINK_W'(CAP);
      end
      free_top = '0;
   endfunction

   function automatic ksa_pkg::rsp_type apply_stack_op(ksa_pkg::req_type w);
      ksa_pkg::rsp_type   r;
      logic [LINK_W-1:0]  slot;
      r.status    = ksa_pkg::ST_OK;
      r.pop_value = '0;
      if (w.operation == ksa_pkg::OP_PUSH) begin
         if (w.stack_id >= STACKS || free_top >= CAP) begin
            r.status = ksa_pkg::ST_OVERFLOW;
         end else begin
            slot                 = free_top;
            slot_data[slot]      = w.push_value;
            free_top             = slot_next[slot];
            slot_next[slot]      = stack_top[w.stack_id];
            stack_top[w.stack_id] = slot;
         end
      end else begin
         if (w.stack_id >= STACKS || stack_top[w.stack_id] >= CAP) begin
            r.status = ksa_pkg::ST_UNDERFLOW;
         end else begin
            slot                 = stack_top[w.stack_id];
            r.pop_value          = slot_data[slot];
            stack_top[w.stack_id] = slot_next[slot];
            slot_next[slot]      = free_top;
            free_top             = slot;
         end
      end
      return r;
   endfunction

   function automatic bit all_stacks_empty();
      for (int i = 0; i < STACKS; i++) begin
         if (stack_top[i] < CAP) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic ksa_pkg::req_type make_word(logic op, int id,
                                                  logic [ksa_pkg::DATA_W-1:0] v);
      ksa_pkg::req_type w;
      w.operation  = op;
      w.stack_id   = ksa_pkg::ID_W'(id);
      w.push_value = v;
      return w;
   endfunction

   function automatic logic [ksa_pkg::DATA_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 40) $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic lower_valid();
      if (drive_high) begin
         req_valid <= 1'b0;
         drive_high = 1'b0;
      end
   endtask

   task automatic send_word(input ksa_pkg::req_type w);
      bit take;
      req_word  <= w;
      req_valid <= 1'b1;
      drive_high = 1'b1;
      do begin
         @(negedge clock);
         take = !req_stall;
         @(posedge clock);
      end while (!take);
      awaited_rsp.push_back(apply_stack_op(w));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         lower_valid();
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_drained();
      lower_valid();
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_kind_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   always begin
      ksa_pkg::rsp_type want;
      @(negedge clock);
      req_take = req_valid && !req_stall;
      rsp_take = rsp_valid && !rsp_stall;
      rsp_seen = rsp_word;
      @(posedge clock);
      if (!reset) begin
         if (rsp_take) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected response %p", rsp_seen));
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_seen.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_seen.status, want.status));
               if (rsp_seen.pop_value !== want.pop_value)
                  report_mismatch($sformatf("pop_value got %h want %h",
                                            rsp_seen.pop_value, want.pop_value));
            end
         end
         if (req_take || rsp_take) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   task automatic test_empty_pops();
      for (int id = 0; id < STACKS; id++) begin
         send_word(make_word(ksa_pkg::OP_POP, id, '1));
      end
   endtask

   task automatic test_value_extremes();
      send_word(make_word(ksa_pkg::OP_PUSH, 0, 32'h8000_0000));
      send_word(make_word(ksa_pkg::OP_PUSH, 0, 32'h7FFF_FFFF));
      send_word(make_word(ksa_pkg::OP_POP,  0, 32'h1234_5678));
      send_word(make_word(ksa_pkg::OP_POP,  0, '0));
      send_word(make_word(ksa_pkg::OP_PUSH, 1, '1));
      send_word(make_word(ksa_pkg::OP_PUSH, 2, '0));
      send_word(make_word(ksa_pkg::OP_PUSH, 3, 32'h5555_5555));
      send_word(make_word(ksa_pkg::OP_PUSH, 3, 32'hAAAA_AAAA));
      send_word(make_word(ksa_pkg::OP_POP,  3, '1));
      send_word(make_word(ksa_pkg::OP_POP,  1, '0));
      send_word(make_word(ksa_pkg::OP_POP,  2, '0));
      send_word(make_word(ksa_pkg::OP_POP,  3, '0));
      send_word(make_word(ksa_pkg::OP_POP,  1, '0));
   endtask

   task automatic test_fill_and_drain(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         while (free_top < CAP) begin
            send_word(make_word(ksa_pkg::OP_PUSH, $urandom_range(0, STACKS - 1),
                                random_value()));
         end
         repeat ($urandom_range(1, 3)) begin
            send_word(make_word(ksa_pkg::OP_PUSH, $urandom_range(0, STACKS - 1),
                                random_value()));
         end
         if (r % 2 == 1) wait_drained();
         while (!all_stacks_empty()) begin
            send_word(make_word(ksa_pkg::OP_POP, $urandom_range(0, STACKS - 1),
                                $urandom));
         end
         send_word(make_word(ksa_pkg::OP_POP, $urandom_range(0, STACKS - 1), $urandom));
      end
   endtask

   task automatic test_mixed_traffic(input int count);
      int  push_pct;
      logic op;
      push_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 20;
               1: push_pct = 50;
               default: push_pct = 80;
            endcase
         end
         op = ($urandom_range(0, 99) < push_pct) ? ksa_pkg::OP_PUSH : ksa_pkg::OP_POP;
         send_word(make_word(op, $urandom_range(0, STACKS - 1),
                             (op == ksa_pkg::OP_PUSH) ? random_value() : $urandom));
      end
   endtask

   initial begin
      reset_stacks();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pops();
      test_value_extremes();
      wait_drained();
      test_fill_and_drain(4);
      wait_drained();
      test_mixed_traffic(340);
      lower_valid();
      do @(posedge clock); while (awaited_rsp.size() != 0);
      repeat (TAIL_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
